// ----- hw/rtl/dee_pkg.sv -----
`default_nettype none
package dee_pkg;

   // item modes
   localparam logic [1:0] MODE_READ  = 2'd0;
   localparam logic [1:0] MODE_WRITE = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // register selects
   localparam logic [2:0] SEL_ADDR_HIGH = 3'd0;
   localparam logic [2:0] SEL_ADDR_LOW  = 3'd1;
   localparam logic [2:0] SEL_DATA      = 3'd2;
   localparam logic [2:0] SEL_CONTROL   = 3'd3;
   localparam logic [2:0] SEL_UNLOCK    = 3'd4;

   // control register bit positions
   localparam int CTL_RD_BIT   = 0;
   localparam int CTL_WR_BIT   = 1;
   localparam int CTL_WREN_BIT = 2;

   // unlock sequence
   localparam logic [7:0] UNLOCK_KEY_FIRST  = 8'h55;
   localparam logic [7:0] UNLOCK_KEY_SECOND = 8'hAA;
   localparam logic [1:0] UNLOCK_LOCKED     = 2'd0;
   localparam logic [1:0] UNLOCK_SAW_FIRST  = 2'd1;
   localparam logic [1:0] UNLOCK_OPEN       = 2'd2;

   localparam logic [7:0] ADDR_HIGH_MASK = 8'h03;
   localparam logic [7:0] ERASED_BYTE    = 8'hFF;

   // csr register indexes
   localparam logic [0:0] CSR_WRITE_TICKS = 1'b0;

   localparam int          DEF_MEM_DEPTH   = 1024;
   localparam logic [15:0] DEF_WRITE_TICKS = 16'd4;

endpackage
`default_nettype wire

// ----- hw/rtl/data_eeprom_controller.sv -----
`default_nettype none
// Data EEPROM controller with a byte register interface (address high, address
// low, data, control, unlock) in front of a MEM_DEPTH byte store held in one
// single-port synchronous RAM. Each request transfer is a register read, a
// register write or a time tick, and yields one response transfer. A control
// write that sets the read bit, with no write cycle running or starting, holds
// off the next item while the RAM read data is registered and then loaded into
// the data register. A write to either address register holds off the next
// item while the address reduction pipeline (address modulo MEM_DEPTH)
// settles. A started write cycle stays busy for write_ticks tick items (zero
// counts as one) and commits the latched byte on the last tick. After reset a
// clearing pass writes 0xFF to every RAM entry, one per cycle, and no request
// is accepted until it ends; csr writes are taken as always. write_ticks lies
// at csr byte address 0.
module data_eeprom_controller
   import dee_pkg::*;
#(
   parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_mode,
   input  wire logic [2:0]  req_reg_select,
   input  wire logic [7:0]  req_write_data,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_busy_res,
   output logic             rsp_error,
   // csr port
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);

   localparam int ADDR_W  = $clog2(MEM_DEPTH);
   localparam int RAW_W   = 10;
   localparam int SHIFT   = 2 * RAW_W;
   localparam int RECIP   = (1 << SHIFT) / MEM_DEPTH;
   localparam int RECIP_W = $clog2(RECIP + 1);
   localparam int PROD_W  = RAW_W + RECIP_W;

   localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(MEM_DEPTH - 1);
   localparam logic [RAW_W:0]    DEPTH_C  = (RAW_W + 1)'(MEM_DEPTH);

   // byte store
   logic [7:0]        mem [MEM_DEPTH];
   logic [7:0]        mem_q_ff;
   logic              mem_we;
   logic              mem_re;
   logic [ADDR_W-1:0] mem_widx;
   logic [7:0]        mem_wdata;

   // registers
   logic [1:0]        addr_high_ff, addr_high_in;
   logic [7:0]        addr_low_ff, addr_low_in;
   logic [7:0]        data_reg_ff, data_reg_in;
   logic [7:0]        control_ff, control_in;
   logic [1:0]        unlock_ff, unlock_in;
   logic [15:0]       count_ff, count_in;
   logic [ADDR_W-1:0] pend_addr_ff, pend_addr_in;
   logic [7:0]        pend_byte_ff, pend_byte_in;
   logic [15:0]       write_ticks_ff, write_ticks_in;
   logic              load_ff, load_in;
   logic [1:0]        settle_ff, settle_in;
   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_idx_ff, clear_idx_in;

   // response output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_data_ff, rsp_data_in;
   logic              rsp_busy_ff, rsp_busy_in;
   logic              rsp_error_ff, rsp_error_in;

   // address reduction pipeline
   logic [RAW_W-1:0]  raw_ff;
   logic [RAW_W-1:0]  quot_ff;
   logic [ADDR_W-1:0] addr_mod_ff;
   logic [RAW_W-1:0]  raw_addr;
   logic [PROD_W-1:0] recip_prod;
   logic [SHIFT-1:0]  quot_depth;
   logic [RAW_W:0]    rem_c;
   logic [RAW_W:0]    rem_fix;

   logic              req_accept;
   logic              csr_write;
   logic              busy;
   logic              start_write;
   logic              do_read;
   logic [7:0]        ctl_merged;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = clearing_ff || load_ff || (settle_ff != 2'd0) ||
                       (rsp_valid_ff && rsp_stall);
   assign busy       = (count_ff != 16'd0);

   // csr access
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == CSR_WRITE_TICKS) ? {16'd0, write_ticks_ff} : 32'd0;

   always_comb begin
      write_ticks_in = write_ticks_ff;
      if (csr_write && csr_paddr[2] == CSR_WRITE_TICKS) begin
         write_ticks_in = csr_pwdata[15:0];
      end
   end

   // address modulo depth: reciprocal multiply, then one correction
   assign raw_addr   = {addr_high_ff, addr_low_ff};
   assign recip_prod = PROD_W'(raw_addr) * PROD_W'(RECIP);
   assign quot_depth = SHIFT'(quot_ff) * SHIFT'(MEM_DEPTH);
   assign rem_c      = {1'b0, raw_ff} - quot_depth[RAW_W:0];
   assign rem_fix    = (rem_c >= DEPTH_C) ? (rem_c - DEPTH_C) : rem_c;

   always_ff @(posedge clock) begin
      raw_ff      <= raw_addr;
      quot_ff     <= RAW_W'(recip_prod >> SHIFT);
      addr_mod_ff <= rem_fix[ADDR_W-1:0];
   end

   // merged control value for a control write
   assign ctl_merged = {req_write_data[7:2], control_ff[CTL_WR_BIT], 1'b0};

   // item processing
   always_comb begin
      addr_high_in = addr_high_ff;
      addr_low_in  = addr_low_ff;
      data_reg_in  = data_reg_ff;
      control_in   = control_ff;
      unlock_in    = unlock_ff;
      count_in     = count_ff;
      pend_addr_in = pend_addr_ff;
      pend_byte_in = pend_byte_ff;
      load_in      = 1'b0;
      settle_in    = (settle_ff != 2'd0) ? settle_ff - 2'd1 : 2'd0;
      clearing_in  = clearing_ff;
      clear_idx_in = clear_idx_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_widx     = pend_addr_ff;
      mem_wdata    = pend_byte_ff;
      start_write  = 1'b0;
      do_read      = 1'b0;
      rsp_data_in  = 8'd0;
      rsp_error_in = 1'b0;

      // loaded byte arrives in the cycle after the read
      if (load_ff) begin
         data_reg_in = mem_q_ff;
      end

      // erase pass after reset
      if (clearing_ff) begin
         mem_we       = 1'b1;
         mem_widx     = clear_idx_ff;
         mem_wdata    = ERASED_BYTE;
         clear_idx_in = clear_idx_ff + 1'b1;
         if (clear_idx_ff == LAST_IDX) begin
            clearing_in = 1'b0;
         end
      end

      if (req_accept) begin
         case (req_mode)
            MODE_READ: begin
               case (req_reg_select)
                  SEL_ADDR_HIGH: rsp_data_in = {6'd0, addr_high_ff};
                  SEL_ADDR_LOW:  rsp_data_in = addr_low_ff;
                  SEL_DATA:      rsp_data_in = data_reg_ff;
                  SEL_CONTROL:   rsp_data_in = control_ff;
                  default:       rsp_data_in = 8'd0;
               endcase
            end
            MODE_WRITE: begin
               case (req_reg_select)
                  SEL_ADDR_HIGH: begin
                     addr_high_in = req_write_data[1:0] & ADDR_HIGH_MASK[1:0];
                     unlock_in    = UNLOCK_LOCKED;
                     settle_in    = 2'd2;
                  end
                  SEL_ADDR_LOW: begin
                     addr_low_in = req_write_data;
                     unlock_in   = UNLOCK_LOCKED;
                     settle_in   = 2'd2;
                  end
                  SEL_DATA: begin
                     data_reg_in = req_write_data;
                     unlock_in   = UNLOCK_LOCKED;
                  end
                  SEL_CONTROL: begin
                     control_in = ctl_merged;
                     if (req_write_data[CTL_WR_BIT] && !busy) begin
                        if (req_write_data[CTL_WREN_BIT] && unlock_ff == UNLOCK_OPEN) begin
                           start_write            = 1'b1;
                           pend_addr_in           = addr_mod_ff;
                           pend_byte_in           = data_reg_ff;
                           count_in               = (write_ticks_ff == 16'd0) ? 16'd1
                                                                              : write_ticks_ff;
                           control_in[CTL_WR_BIT] = 1'b1;
                        end else begin
                           rsp_error_in = 1'b1;
                        end
                     end
                     // read only when no cycle is running after the decision
                     if (req_write_data[CTL_RD_BIT] && !busy && !start_write) begin
                        do_read = 1'b1;
                        mem_re  = 1'b1;
                        load_in = 1'b1;
                     end
                     unlock_in = UNLOCK_LOCKED;
                  end
                  SEL_UNLOCK: begin
                     if (req_write_data == UNLOCK_KEY_FIRST) begin
                        unlock_in = UNLOCK_SAW_FIRST;
                     end else if (req_write_data == UNLOCK_KEY_SECOND &&
                                  unlock_ff == UNLOCK_SAW_FIRST) begin
                        unlock_in = UNLOCK_OPEN;
                     end else begin
                        unlock_in = UNLOCK_LOCKED;
                     end
                  end
                  default: begin
                  end
               endcase
            end
            MODE_TICK: begin
               if (busy) begin
                  count_in = count_ff - 16'd1;
                  if (count_ff == 16'd1) begin
                     mem_we                 = 1'b1;
                     control_in[CTL_WR_BIT] = 1'b0;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      rsp_busy_in = (count_in != 16'd0);
   end

   // response register, holds while stalled
   always_comb begin
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_busy_ff  <= rsp_busy_in;
         rsp_error_ff <= rsp_error_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_error     = rsp_error_ff;

   // store ram
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_widx] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff <= mem[addr_mod_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_addr_ff <= pend_addr_in;
      pend_byte_ff <= pend_byte_in;
      clear_idx_ff <= reset ? '0 : clear_idx_in;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_high_ff   <= 2'd0;
         addr_low_ff    <= 8'd0;
         data_reg_ff    <= 8'd0;
         control_ff     <= 8'd0;
         unlock_ff      <= UNLOCK_LOCKED;
         count_ff       <= 16'd0;
         write_ticks_ff <= DEF_WRITE_TICKS;
         load_ff        <= 1'b0;
         settle_ff      <= 2'd0;
         clearing_ff    <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         addr_high_ff   <= addr_high_in;
         addr_low_ff    <= addr_low_in;
         data_reg_ff    <= data_reg_in;
         control_ff     <= control_in;
         unlock_ff      <= unlock_in;
         count_ff       <= count_in;
         write_ticks_ff <= write_ticks_in;
         load_ff        <= load_in;
         settle_ff      <= settle_in;
         clearing_ff    <= clearing_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // checks
   a_no_accept_while_clearing : assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !req_accept)
      else $error("request taken during erase pass");

   a_wr_bit_tracks_busy : assert property (@(posedge clock) disable iff (reset)
      control_ff[CTL_WR_BIT] == busy)
      else $error("control write bit out of step with write cycle");

   a_load_single_cycle : assert property (@(posedge clock) disable iff (reset)
      do_read && req_accept |=> load_ff && !req_accept)
      else $error("ram load not followed by a held cycle");

   a_no_read_write_overlap : assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("ram read and write in the same cycle");

   a_unlock_stage_range : assert property (@(posedge clock) disable iff (reset)
      (unlock_ff == UNLOCK_LOCKED) || (unlock_ff == UNLOCK_SAW_FIRST) ||
      (unlock_ff == UNLOCK_OPEN))
      else $error("unlock stage holds an unused code");

endmodule
`default_nettype wire
